### hw/rtl/bss_pkg.sv
// Shared types, constants and helpers for the byte signature scanner.
package bss_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 48;
   localparam int START_BITS    = 48;
   localparam int WIN_IDX_W     = $clog2(MAX_PATTERN);
   localparam int FILL_W        = $clog2(MAX_PATTERN + 1);
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_MODE       = 3'd0,
      CSR_SEARCH_BYTE     = 3'd1,
      CSR_BLOCK_SIZE_LOG2 = 3'd2,
      CSR_PATTERN_LOW     = 3'd3,
      CSR_PATTERN_HIGH    = 3'd4,
      CSR_PATTERN_LENGTH  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BYTE   = 2'd0,
      MODE_BLOCK  = 2'd1,
      MODE_STRING = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic                  match;
      logic [START_BITS-1:0] match_start;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  scan_mode;
      logic [7:0]  search_byte;
      logic [5:0]  block_size_log2;
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [4:0]  pattern_length;
   } cfg_type;

   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] window;
      logic [POSITION_BITS-1:0]    position;
      logic [FILL_W-1:0]           fill;
   } stage_type;

   function automatic logic [7:0] pattern_byte(input cfg_type cfg,
                                               input logic [WIN_IDX_W-1:0] idx);
      logic [127:0] pat;
      pat = {cfg.pattern_high, cfg.pattern_low};
      return pat[{idx, 3'b000} +: 8];
   endfunction

endpackage

### hw/rtl/bss_csr.sv
// Configuration registers of the byte signature scanner.
module bss_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [bss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bss_pkg::cfg_type              cfg
);
   import bss_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SCAN_MODE:       cfg_in.scan_mode       = csr_wdata[1:0];
            CSR_SEARCH_BYTE:     cfg_in.search_byte     = csr_wdata[7:0];
            CSR_BLOCK_SIZE_LOG2: cfg_in.block_size_log2 = csr_wdata[5:0];
            CSR_PATTERN_LOW:     cfg_in.pattern_low     = csr_wdata;
            CSR_PATTERN_HIGH:    cfg_in.pattern_high    = csr_wdata;
            CSR_PATTERN_LENGTH:  cfg_in.pattern_length  = csr_wdata[4:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_mode       <= MODE_BYTE;
         cfg_ff.search_byte     <= 8'd0;
         cfg_ff.block_size_log2 <= 6'd9;
         cfg_ff.pattern_low     <= 64'd0;
         cfg_ff.pattern_high    <= 64'd0;
         cfg_ff.pattern_length  <= 5'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/bss_window.sv
// Input stage: byte window, stream position and fill count, registered per beat.
module bss_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bss_pkg::req_type   req_beat,
   input  logic               advance,
   output logic               stage_valid,
   output bss_pkg::stage_type stage
);
   import bss_pkg::*;

   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in, base_window;
   logic [POSITION_BITS-1:0]    pos_ff, pos_in, base_pos;
   logic [FILL_W-1:0]           fill_ff, fill_in, base_fill;
   logic                        stage_valid_ff, stage_valid_in;
   stage_type                   stage_ff, stage_in;
   logic                        accept;

   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_beat.restart) begin
         base_window = '0;
         base_pos    = '0;
         base_fill   = '0;
      end else begin
         base_window = window_ff;
         base_pos    = pos_ff;
         base_fill   = fill_ff;
      end
      window_in = {base_window[MAX_PATTERN-2:0], req_beat.data_byte};
      pos_in    = base_pos + POSITION_BITS'(1);
      if (base_fill == FILL_W'(MAX_PATTERN)) begin
         fill_in = base_fill;
      end else begin
         fill_in = base_fill + FILL_W'(1);
      end
      stage_in.window   = window_in;
      stage_in.position = base_pos;
      stage_in.fill     = fill_in;
      stage_valid_in    = accept || (stage_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept) begin
            window_ff <= window_in;
            pos_ff    <= pos_in;
            fill_ff   <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PATTERN))
      else $error("fill count above window depth");

   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      accept && req_beat.restart |=>
         stage_ff.position == '0 && stage_ff.fill == FILL_W'(1))
      else $error("restart beat not at position zero");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_beat.restart |=> pos_ff == $past(pos_ff) + POSITION_BITS'(1))
      else $error("position did not step by one");

endmodule

### hw/rtl/bss_match.sv
// Match stage: mode compare on the staged window and the result register.
module bss_match (
   input  logic               clock,
   input  logic               reset,
   input  bss_pkg::cfg_type   cfg,
   input  logic               stage_valid,
   input  bss_pkg::stage_type stage,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bss_pkg::rsp_type   rsp_beat
);
   import bss_pkg::*;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [FILL_W-1:0]        len;
   logic [FILL_W-1:0]        pat_idx;
   logic [MAX_PATTERN-1:0]   tap_ok;
   logic [POSITION_BITS-1:0] block_mask;
   logic                     hit;
   logic [POSITION_BITS-1:0] start;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cfg.pattern_length > FILL_W'(MAX_PATTERN)) begin
         len = FILL_W'(MAX_PATTERN);
      end else begin
         len = cfg.pattern_length;
      end

      // tap j holds the byte j steps back; it must equal pattern byte len-1-j
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat_idx   = len - FILL_W'(1) - FILL_W'(j);
         tap_ok[j] = (FILL_W'(j) >= len) ||
                     (stage.window[j] == pattern_byte(cfg, pat_idx[WIN_IDX_W-1:0]));
      end

      if (cfg.block_size_log2 >= 6'(POSITION_BITS)) begin
         block_mask = '1;
      end else begin
         block_mask = ~({POSITION_BITS{1'b1}} << cfg.block_size_log2);
      end

      hit   = 1'b0;
      start = stage.position;
      case (cfg.scan_mode)
         MODE_BYTE: begin
            hit = (stage.window[0] == cfg.search_byte);
         end
         MODE_BLOCK: begin
            hit = ((stage.position & block_mask) == '0);
         end
         MODE_STRING: begin
            hit   = (len != '0) && (stage.fill >= len) && (&tap_ok);
            start = stage.position - POSITION_BITS'(len) + POSITION_BITS'(1);
         end
         default: begin
            hit = 1'b0;
         end
      endcase

      rsp_in.match       = hit;
      rsp_in.match_start = hit ? start[START_BITS-1:0] : '0;
      rsp_valid_in       = advance ? stage_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !advance |=> stage_valid && rsp_valid_ff)
      else $error("staged beat lost while result held");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.match |-> rsp_ff.match_start == '0)
      else $error("start reported without match");

endmodule

### hw/rtl/byte_signature_scanner.sv
// Top level of the byte signature scanner.
// Path: an accepted beat is held in the staged window register, then in the result register.
// Throughput: one byte per cycle while rsp_stall is low; the staged window register and the
//   result register together let a new byte enter while a result waits.
// Reset (synchronous, active high): registers to defaults, window, position
//   and fill count to zero, both pipeline stages empty.
module byte_signature_scanner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bss_pkg::req_type               req_beat,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bss_pkg::rsp_type               rsp_beat,
   input  logic                           csr_write_en,
   input  logic [bss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bss_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_valid;
   logic      advance;

   bss_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bss_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   bss_match u_match (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat)
   );

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !stage_valid)
      else $error("pipeline not empty after reset");

endmodule
